// ===== hdl/sha1_stream_hasher_defines.svh =====
// Assertion macros shared by the SHA-1 stream hasher RTL.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SHA1S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define SHA1S_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/sha1s_pkg.sv =====
// Shared types and constants of the SHA-1 stream hasher.
package sha1s_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1s_vars_t;

  localparam sha1s_vars_t HashInit = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam int unsigned RoundW = 7;
  localparam logic [RoundW-1:0] RoundSched = 7'd16;
  localparam logic [RoundW-1:0] Round20    = 7'd20;
  localparam logic [RoundW-1:0] Round40    = 7'd40;
  localparam logic [RoundW-1:0] Round60    = 7'd60;
  localparam logic [RoundW-1:0] RoundLast  = 7'd79;

  localparam logic [7:0] PadMark = 8'h80;

endpackage

// ===== hdl/sha1s_round.sv =====
// One SHA-1 round: message schedule expansion and the a..e update.
module sha1s_round
  import sha1s_pkg::*;
(
  input  sha1s_vars_t       vars_i,
  input  logic [RoundW-1:0] round_i,
  input  logic [31:0]       w_pair_i,   // W[t-3] ^ W[t-8]
  input  logic [31:0]       w_old_i,    // W[t-14]
  input  logic [31:0]       w_cur_i,    // W[t] as stored
  output sha1s_vars_t       vars_o,
  output logic [31:0]       w_o
);

  logic [31:0] w_mix;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  assign w_mix = w_pair_i ^ w_old_i ^ w_cur_i;
  assign w_o   = (round_i < RoundSched) ? w_cur_i : {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (round_i < Round20) begin
      f = (vars_i.b & vars_i.c) ^ (~vars_i.b & vars_i.d);
      k = K0;
    end else if (round_i < Round40) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K1;
    end else if (round_i < Round60) begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
      k = K2;
    end else begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K3;
    end
  end

  assign tmp = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + k + w_o;

  assign vars_o.a = tmp;
  assign vars_o.b = vars_i.a;
  assign vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
  assign vars_o.d = vars_i.c;
  assign vars_o.e = vars_i.d;

endmodule

// ===== hdl/sha1_stream_hasher.sv =====
// Top level of the SHA-1 stream hasher: byte intake, padding, rounds, digest out.
//
//   channel | direction | beat payload                          | handshake
//   --------+-----------+---------------------------------------+-------------------------
//   in      | input     | data_byte_i, byte_valid_i, last_i     | in_valid_i / in_ready_o
//   out     | output    | digest_word_o, word_index_o, last_word_o | out_valid_o / out_ready_i
//
// Sequence: a byte that does not close a 64-byte block is only packed in. A full block
// then passes ST_LOAD (copy hash into a..e), 80 rounds in phases ST_RD and ST_EX (the
// schedule memory has two read ports and a round needs four schedule words), and ST_ADD
// (add into the hash). A last beat adds the padding bytes (9 to 72) plus one or two
// block compressions, then ST_DONE hands the digest to the output buffer.
// Reset: hash words return to the standard initial values, length and position clear.
// Stalls: the digest sits in its own buffer, so the next message streams in while
// the five words drain; only a second digest waits until the buffer is empty.
`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher
  import sha1s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // take message bytes
  localparam logic [2:0] ST_PAD  = 3'd1;  // insert padding and length bytes
  localparam logic [2:0] ST_LOAD = 3'd2;  // copy hash into a..e
  localparam logic [2:0] ST_RD   = 3'd3;  // round phase 0: fetch W[t-14], W[t]
  localparam logic [2:0] ST_EX   = 3'd4;  // round phase 1: compute, write W[t]
  localparam logic [2:0] ST_ADD  = 3'd5;  // fold a..e into the hash
  localparam logic [2:0] ST_DONE = 3'd6;  // hand digest to the output buffer

  // Padding progress.
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_MARK = 2'd1;
  localparam logic [1:0] PAD_ZERO = 2'd2;
  localparam logic [1:0] PAD_LEN  = 2'd3;

  localparam logic [5:0] PosLenStart = 6'd56;
  localparam logic [5:0] PosLast     = 6'd63;
  localparam logic [2:0] WordLast    = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [1:0]        pad_q, pad_d;
  logic [RoundW-1:0] round_q, round_d;
  logic [5:0]        pos_q, pos_d;
  logic [63:0]       cnt_q, cnt_d;
  logic [23:0]       acc_q, acc_d;
  sha1s_vars_t       hash_q, hash_d;
  sha1s_vars_t       work_q, work_d;
  sha1s_vars_t       round_vars;
  sha1s_vars_t       digest_q;
  logic [31:0]       w_pair_q;
  logic [31:0]       w_next;

  logic              out_busy_q;
  logic [2:0]        out_idx_q;
  logic              digest_load;

  logic              put_en;
  logic [7:0]        put_byte;
  logic [2:0]        len_sel;
  logic [7:0]        len_byte;

  // Schedule memory: one write port, two registered read ports.
  logic [31:0]       sched_mem [16];
  logic              mem_we;
  logic [3:0]        mem_waddr;
  logic [31:0]       mem_wdata;
  logic [3:0]        raddr_a, raddr_b;
  logic [31:0]       rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sched_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= sched_mem[raddr_a];
    rd_b_q <= sched_mem[raddr_b];
  end

  // Read addresses. Phase 0 of round t fetches W[t-14] and W[t]; the cycle before
  // it fetches W[t-3] and W[t-8]. The write of W[t] in phase 1 never hits an entry
  // fetched in the same cycle, so no forwarding is needed.
  always_comb begin
    unique case (state_q)
      ST_RD: begin
        raddr_a = round_q[3:0] + 4'd2;
        raddr_b = round_q[3:0];
      end
      ST_EX: begin
        raddr_a = round_q[3:0] - 4'd2;
        raddr_b = round_q[3:0] + 4'd9;
      end
      default: begin
        raddr_a = 4'd13;
        raddr_b = 4'd8;
      end
    endcase
  end

  sha1s_round u_round (
    .vars_i   (work_q),
    .round_i  (round_q),
    .w_pair_i (w_pair_q),
    .w_old_i  (rd_a_q),
    .w_cur_i  (rd_b_q),
    .vars_o   (round_vars),
    .w_o      (w_next)
  );

  // Length bytes go out most significant first at block positions 56..63.
  assign len_sel  = 3'd7 - pos_q[2:0];
  assign len_byte = cnt_q[{len_sel, 3'b000} +: 8];

  always_comb begin
    state_d     = state_q;
    pad_d       = pad_q;
    round_d     = round_q;
    cnt_d       = cnt_q;
    hash_d      = hash_q;
    work_d      = work_q;
    digest_load = 1'b0;
    put_en      = 1'b0;
    put_byte    = 8'h00;
    pos_d       = pos_q;
    acc_d       = acc_q;
    mem_we      = 1'b0;
    mem_waddr   = round_q[3:0];
    mem_wdata   = w_next;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          put_en   = byte_valid_i;
          put_byte = data_byte_i;
          if (byte_valid_i) begin
            cnt_d = cnt_q + 64'd8;
          end
          if (last_i) begin
            pad_d = PAD_MARK;
          end
          if (byte_valid_i && pos_q == PosLast) begin
            state_d = ST_LOAD;
          end else if (last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        put_en = 1'b1;
        case (pad_q)
          PAD_MARK: begin
            put_byte = PadMark;
            pad_d    = PAD_ZERO;
          end
          PAD_ZERO: begin
            if (pos_q == PosLenStart) begin
              put_byte = len_byte;
              pad_d    = PAD_LEN;
            end
          end
          PAD_LEN: put_byte = len_byte;
          default: put_byte = 8'h00;
        endcase
        if (pos_q == PosLast) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        work_d  = hash_q;
        round_d = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_EX;
      end
      ST_EX: begin
        work_d = round_vars;
        mem_we = (round_q >= RoundSched);
        if (round_q == RoundLast) begin
          state_d = ST_ADD;
        end else begin
          round_d = round_q + 7'd1;
          state_d = ST_RD;
        end
      end
      ST_ADD: begin
        hash_d.a = hash_q.a + work_q.a;
        hash_d.b = hash_q.b + work_q.b;
        hash_d.c = hash_q.c + work_q.c;
        hash_d.d = hash_q.d + work_q.d;
        hash_d.e = hash_q.e + work_q.e;
        if (pad_q == PAD_LEN) begin
          state_d = ST_DONE;
        end else if (pad_q != PAD_NONE) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        // Hold until the previous digest has drained, then restart the hash.
        if (!out_busy_q) begin
          digest_load = 1'b1;
          hash_d      = HashInit;
          cnt_d       = '0;
          pad_d       = PAD_NONE;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Pack bytes big-endian; the fourth byte of a word writes it to the schedule.
    if (put_en) begin
      acc_d = {acc_q[15:0], put_byte};
      pos_d = pos_q + 6'd1;
      if (pos_q[1:0] == 2'd3) begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[5:2];
        mem_wdata = {acc_q, put_byte};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= PAD_NONE;
      round_q <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      hash_q  <= HashInit;
      work_q  <= '0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      round_q <= round_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      hash_q  <= hash_d;
      work_q  <= work_d;
    end
  end

  // Payload registers: byte accumulator and the W[t-3] ^ W[t-8] partial.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (state_q == ST_RD) begin
      w_pair_q <= rd_a_q ^ rd_b_q;
    end
    if (digest_load) begin
      digest_q <= hash_q;
    end
  end

  // Digest buffer: drain five beats, h0 first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_busy_q <= 1'b0;
      out_idx_q  <= '0;
    end else if (digest_load) begin
      out_busy_q <= 1'b1;
      out_idx_q  <= '0;
    end else if (out_busy_q && out_ready_i) begin
      if (out_idx_q == WordLast) begin
        out_busy_q <= 1'b0;
        out_idx_q  <= '0;
      end else begin
        out_idx_q <= out_idx_q + 3'd1;
      end
    end
  end

  always_comb begin
    case (out_idx_q)
      3'd0:    digest_word_o = digest_q.a;
      3'd1:    digest_word_o = digest_q.b;
      3'd2:    digest_word_o = digest_q.c;
      3'd3:    digest_word_o = digest_q.d;
      default: digest_word_o = digest_q.e;
    endcase
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_busy_q;
  assign word_index_o = out_idx_q;
  assign last_word_o  = (out_idx_q == WordLast);

  // A block is only compressed when all 64 bytes are in.
  `SHA1S_ASSERT(a_full_block, (state_q == ST_ADD) |-> (pos_q == '0), "compress of partial block")
  // Rounds never run past the last one.
  `SHA1S_ASSERT_NEVER(a_round_range, (state_q == ST_EX) && (round_q > RoundLast), "round overrun")
  // A finished digest lands in the buffer and the block returns to intake.
  `SHA1S_ASSERT(a_digest_handoff, (state_q == ST_DONE && !out_busy_q) |=> (out_busy_q && out_idx_q == '0 && state_q == ST_IDLE), "digest handoff lost")
  // Intake never sees leftover padding state.
  `SHA1S_ASSERT(a_idle_clean, (state_q == ST_IDLE) |-> (pad_q == PAD_NONE), "padding left active at intake")

endmodule
